>>> rtl/lpn_pkg.sv
// Package for the look-ahead peak normaliser: widths, constants and the
// divider result type. No dependencies; every other file uses it.
package lpn_pkg;

   localparam int WINDOW_MAX_DEF = 1024;
   localparam int SAMPLE_W       = 16;
   localparam int WLEN_W         = 11;
   localparam int LEVEL_W        = 15;
   localparam int CSR_DATA_W     = 15;
   localparam int CSR_INDEX_W    = 1;
   localparam int GAIN_W         = 32;
   localparam int SLOPE_W        = 33;
   localparam int PEAK_W         = 16;
   localparam int DIV_W          = 32;
   localparam int DVS_W          = 16;
   localparam int DIV_CNT_W      = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LEN   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_LEVEL = 1'b1;

   localparam logic [WLEN_W-1:0]  WLEN_RESET  = 11'd1024;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 15'd32767;
   localparam logic [GAIN_W-1:0]  GAIN_UNITY  = 32'h0001_0000;
   // Target gain used when both window peaks are silent (200000 in Q16.16 per unit level).
   localparam logic [17:0]        SILENT_GAIN = 18'd200000;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_result_type;

endpackage

>>> rtl/lpn_if.sv
// Word channels of the look-ahead peak normaliser: valid/ready plus payload.
// Depends on lpn_pkg.
interface lpn_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lpn_pkg::SAMPLE_W-1:0]  in_sample;
   modport source (output valid, output in_sample, input ready);
   modport sink   (input valid, input in_sample, output ready);
endinterface

interface lpn_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lpn_pkg::SAMPLE_W-1:0]  out_sample;
   modport source (output valid, output out_sample, input ready);
   modport sink   (input valid, input out_sample, output ready);
endinterface

>>> rtl/lookahead_peak_normaliser.sv
// Look-ahead peak normaliser top level with its two-bank sample memory.
// Depends on lpn_pkg, lpn_if and lpn_divider.
//
// Each input word returns one output word: the sample from two windows earlier,
// scaled by the running Q16.16 gain, rounded and saturated; output is zero for
// the first two windows. One word is in flight at a time. An ordinary word
// passes from acceptance through multiply and output load back to idle, and
// waits in output load while the output register is still full. The last
// word of a window adds two divisions on the shared serial divider (target
// gain, then slope); the target-gain division is skipped when both window
// peaks are zero. The sample memory has no reset; an entry can be read before
// it is ever written, as in the first two windows, whose output is zero.
module lookahead_peak_normaliser #(
   parameter int WINDOW_MAX = lpn_pkg::WINDOW_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   lpn_req_if.sink                             req_ch,
   lpn_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [lpn_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lpn_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import lpn_pkg::*;

   localparam int POS_W  = $clog2(WINDOW_MAX);
   localparam int ADDR_W = POS_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;

   typedef enum logic [6:0] {
      S_IDLE = 7'b000_0001,
      S_MUL  = 7'b000_0010,
      S_OUT  = 7'b000_0100,
      S_TGT  = 7'b000_1000,
      S_DIV1 = 7'b001_0000,
      S_DIFF = 7'b010_0000,
      S_DIV2 = 7'b100_0000
   } state_type;

   logic signed [SAMPLE_W-1:0] mem [DEPTH];

   state_type                  state_ff, state_in;
   logic [WLEN_W-1:0]          wlen_ff;
   logic [LEVEL_W-1:0]         level_ff;
   logic [POS_W-1:0]           pos_ff;
   logic                       bank_ff;
   logic [1:0]                 wdone_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic signed [SLOPE_W-1:0]  slope_ff;
   logic [PEAK_W-1:0]          peak_cur_ff;
   logic [PEAK_W-1:0]          peak_prev_ff;
   logic [PEAK_W-1:0]          peak_max_ff;
   logic                       end_ff;
   logic                       out_en_ff;
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic signed [SAMPLE_W-1:0] smp_ff;
   logic signed [48:0]         prod_ff;
   logic [GAIN_W-1:0]          target_ff;
   logic                       diff_neg_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   logic                       accept;
   logic                       out_load;
   logic [ADDR_W-1:0]          addr;
   logic [WLEN_W-1:0]          eff_len;
   logic signed [33:0]         gain_sum;
   logic [GAIN_W-1:0]          gain_next;
   logic [SAMPLE_W:0]          mag_wide;
   logic [PEAK_W-1:0]          mag;
   logic [PEAK_W-1:0]          peak_new;
   logic                       win_end;
   logic signed [48:0]         rounded;
   logic signed [32:0]         scaled;
   logic signed [SAMPLE_W-1:0] sat_val;
   logic [32:0]                silent_prod;
   logic signed [SLOPE_W:0]    diff;
   logic [DIV_W-1:0]           diff_mag;
   logic                       div_start;
   logic [DIV_W-1:0]           div_dividend;
   logic [DVS_W-1:0]           div_divisor;
   div_result_type             div_res;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);
   assign addr     = {bank_ff, pos_ff};

   always_comb begin
      if (wlen_ff == '0) begin
         eff_len = WLEN_W'(1);
      end else if (32'(wlen_ff) > WINDOW_MAX) begin
         eff_len = WLEN_W'(WINDOW_MAX);
      end else begin
         eff_len = wlen_ff;
      end
   end

   // Gain moves by the slope and is clamped to the unsigned 32-bit range.
   assign gain_sum = $signed({2'b00, gain_ff}) + $signed({slope_ff[SLOPE_W-1], slope_ff});
   always_comb begin
      if (gain_sum < 0) begin
         gain_next = '0;
      end else if (gain_sum[33:32] != 2'b00) begin
         gain_next = '1;
      end else begin
         gain_next = gain_sum[31:0];
      end
   end

   assign mag_wide = smp_ff[SAMPLE_W-1] ? -{smp_ff[SAMPLE_W-1], smp_ff}
                                        : {smp_ff[SAMPLE_W-1], smp_ff};
   assign mag      = mag_wide[PEAK_W-1:0];
   assign peak_new = (mag > peak_cur_ff) ? mag : peak_cur_ff;
   assign win_end  = (32'(pos_ff) + 32'd1) >= 32'(eff_len);

   assign rounded = prod_ff + 49'sd32768;
   assign scaled  = rounded[48:16];
   always_comb begin
      if (scaled > 33'sd32767) begin
         sat_val = 16'sh7FFF;
      end else if (scaled < -33'sd32768) begin
         sat_val = -16'sh8000;
      end else begin
         sat_val = scaled[SAMPLE_W-1:0];
      end
   end

   assign silent_prod = 33'(level_ff) * 33'(SILENT_GAIN);
   assign diff = $signed({2'b00, target_ff}) - $signed({2'b00, gain_ff});
   assign diff_mag = diff[SLOPE_W] ? DIV_W'(-diff) : DIV_W'(diff);

   always_comb begin
      div_start    = 1'b0;
      div_dividend = diff_mag;
      div_divisor  = DVS_W'(eff_len);
      unique case (state_ff)
         S_TGT: begin
            div_start    = peak_max_ff != '0;
            div_dividend = DIV_W'({level_ff, 16'h0000});
            div_divisor  = peak_max_ff;
         end
         S_DIFF: begin
            div_start = 1'b1;
         end
         default: begin
         end
      endcase
   end

   lpn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_MUL;
         S_MUL:  state_in = S_OUT;
         S_OUT:  if (out_load) state_in = end_ff ? S_TGT : S_IDLE;
         S_TGT:  state_in = (peak_max_ff == '0) ? S_DIFF : S_DIV1;
         S_DIV1: if (div_res.done) state_in = S_DIFF;
         S_DIFF: state_in = S_DIV2;
         S_DIV2: if (div_res.done) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Read-first memory: the word two windows old comes out as the new one goes in.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff     <= mem[addr];
         mem[addr] <= req_ch.in_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff    <= req_ch.in_sample;
         out_en_ff <= wdone_ff == 2'd2;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= 49'(rd_ff) * $signed({1'b0, gain_ff});
         end_ff  <= win_end;
         if (win_end) begin
            peak_max_ff <= (peak_prev_ff > peak_new) ? peak_prev_ff : peak_new;
         end
      end
      if (state_ff == S_TGT && peak_max_ff == '0) begin
         target_ff <= silent_prod[32] ? '1 : silent_prod[31:0];
      end else if (state_ff == S_DIV1 && div_res.done) begin
         target_ff <= div_res.quotient;
      end
      if (state_ff == S_DIFF) begin
         diff_neg_ff <= diff[SLOPE_W];
      end
      if (out_load) begin
         rsp_data_ff <= out_en_ff ? sat_val : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wlen_ff      <= WLEN_RESET;
         level_ff     <= LEVEL_RESET;
         pos_ff       <= '0;
         bank_ff      <= 1'b0;
         wdone_ff     <= '0;
         gain_ff      <= GAIN_UNITY;
         slope_ff     <= '0;
         peak_cur_ff  <= '0;
         peak_prev_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WINDOW_LEN:   wlen_ff  <= csr_wdata[WLEN_W-1:0];
               CSR_TARGET_LEVEL: level_ff <= csr_wdata[LEVEL_W-1:0];
               default: begin
               end
            endcase
         end
         if (state_ff == S_MUL) begin
            gain_ff <= gain_next;
            if (win_end) begin
               peak_prev_ff <= peak_new;
               peak_cur_ff  <= '0;
               pos_ff       <= '0;
               bank_ff      <= ~bank_ff;
               if (wdone_ff != 2'd2) begin
                  wdone_ff <= wdone_ff + 2'd1;
               end
            end else begin
               peak_cur_ff <= peak_new;
               pos_ff      <= pos_ff + 1'b1;
            end
         end
         if (state_ff == S_DIV2 && div_res.done) begin
            slope_ff <= diff_neg_ff ? -$signed({1'b0, div_res.quotient})
                                    :  $signed({1'b0, div_res.quotient});
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ch.ready      = state_ff == S_IDLE;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_sample = rsp_data_ff;

`ifndef ASSERT_OFF
   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_MUL)
      else $error("accepted word did not move to the multiply step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> !$past(out_load))
      else $error("output word overwritten while still waiting");

   a_windows_sat: assert property (@(posedge clock) disable iff (reset)
      (wdone_ff == 2'd2) |=> (wdone_ff == 2'd2))
      else $error("completed window count left saturation");
`endif

endmodule

>>> rtl/lpn_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lpn_pkg.
module lpn_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lpn_pkg::DIV_W-1:0]   dividend,
   input  logic [lpn_pkg::DVS_W-1:0]   divisor,
   output lpn_pkg::div_result_type     result
);
   import lpn_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DVS_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DVS_W-1:0]     dvs_ff;
   logic [DVS_W:0]       shifted;
   logic [DVS_W:0]       trial;
   logic                 fits;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == {DIV_CNT_W{1'b1}}) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule
